// File: sv/pvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_pkg: shared types and constants
// Operation and status codes, voice states, command/status bundles.
// ----------------------------------------------------------------------------
package pvm_pkg;
  localparam int VOICES_DEF      = 4;
  localparam int MAX_SOUNDS_DEF  = 16;
  localparam int PCM_DEPTH_DEF   = 65536;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_PAUSE  = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;
  localparam logic [2:0] OP_LENTRY = 3'd6;
  localparam logic [2:0] OP_LPCM   = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ID   = 3'd1;
  localparam logic [2:0] ST_NO_VOICE = 3'd2;
  localparam logic [2:0] ST_NO_HDL   = 3'd3;
  localparam logic [2:0] ST_NOT_FND  = 3'd4;

  localparam logic [1:0] VS_FREE  = 2'd0;
  localparam logic [1:0] VS_PLAY  = 2'd1;
  localparam logic [1:0] VS_PAUSE = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  snd_sel;
    logic        looping;
    logic [15:0] handle;
    logic [15:0] address;
    logic [15:0] length;
    logic [15:0] pcm_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] mixed_sample;
    logic [2:0]  voices_mixed;
    logic [15:0] handle_out;
    logic [15:0] position;
    logic [2:0]  status;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic exec;       // do non-tick op / first step
    logic vstart;     // start a voice visit (issue reads)
    logic vfinish;    // finish voice visit (memory data valid)
    logic try_hdl;    // try one handle candidate
    logic finish;     // build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] operation;
    logic       last_voice;
    logic       play_ok;   // play checks passed, need handle search
    logic       hdl_done;  // handle search finished
  } stat_t;
endpackage
`default_nettype wire

// File: sv/pvm_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_stream_if: valid/ready channel
// Carries one payload beat per handshake.
// ----------------------------------------------------------------------------
interface pvm_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/pvm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module pvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/pvm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_ctrl: sequencer
// Steps an item through latch, per-voice tick visits or handle search, result.
// ----------------------------------------------------------------------------
module pvm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           res_busy,
  input  wire pvm_pkg::stat_t st,
  output logic                in_ready,
  output pvm_pkg::cmd_t       cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_VRD   = 3'd2;
  localparam logic [2:0] S_VWAIT = 3'd3;
  localparam logic [2:0] S_VDONE = 3'd4;
  localparam logic [2:0] S_HDL   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.operation == pvm_pkg::OP_TICK) state_nxt = S_VRD;
        else if (st.operation == pvm_pkg::OP_PLAY && st.play_ok) state_nxt = S_HDL;
        else state_nxt = S_OUT;
      end
      S_VRD: begin
        cmd.vstart = 1'b1;
        state_nxt = S_VWAIT;
      end
      S_VWAIT: state_nxt = S_VDONE;
      S_VDONE: begin
        cmd.vfinish = 1'b1;
        state_nxt = st.last_voice ? S_OUT : S_VRD;
      end
      S_HDL: begin
        cmd.try_hdl = 1'b1;
        if (st.hdl_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.vstart, cmd.vfinish, cmd.try_hdl, cmd.finish}))
    else $error("more than one command");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready) else $error("finish did not return to idle");
  a_latch_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> cmd.exec) else $error("latch not followed by exec");
endmodule
`default_nettype wire

// File: sv/pvm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_dp: voice registers, sound table, pcm memory, mixer accumulator
// Executes the commands of the sequencer one voice or one candidate a step.
// ----------------------------------------------------------------------------
module pvm_dp #(
  parameter int VOICES      = pvm_pkg::VOICES_DEF,
  parameter int MAX_SOUNDS  = pvm_pkg::MAX_SOUNDS_DEF,
  parameter int PCM_DEPTH   = pvm_pkg::PCM_DEPTH_DEF,
  parameter int HANDLE_BITS = pvm_pkg::HANDLE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pvm_pkg::cmd_t    cmd,
  input  wire pvm_pkg::item_t   item,
  input  wire logic [4:0]       sound_count,
  output pvm_pkg::stat_t        st,
  output pvm_pkg::result_t      res
);
  localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SB = (MAX_SOUNDS > 1) ? $clog2(MAX_SOUNDS) : 1;
  localparam int PB = $clog2(PCM_DEPTH);
  localparam int CB = $clog2(VOICES + 2);
  localparam logic [HANDLE_BITS-1:0] HMAX = {HANDLE_BITS{1'b1}};
  localparam int ACCB = 21;

  pvm_pkg::item_t it_r;
  logic [1:0]             vstate_r [VOICES];
  logic [HANDLE_BITS-1:0] vhdl_r   [VOICES];
  logic [3:0]             vsnd_r   [VOICES];
  logic [15:0]            vcur_r   [VOICES];
  logic                   vloop_r  [VOICES];
  logic [HANDLE_BITS-1:0] nh_r;
  logic [VB-1:0]          vi_r;
  logic [CB-1:0]          tries_r;
  logic                   got_r;
  logic [2:0]             status_r;
  logic [15:0]            pos_r;
  logic [HANDLE_BITS-1:0] hout_r;
  logic [VB-1:0]          slot_r;
  logic signed [ACCB-1:0] acc_r;
  logic [2:0]             nmix_r;
  logic [15:0]            len_r;
  logic [15:0]            curv_r;
  logic                   vplay_r;

  // sound table: start and length, one port each
  logic [SB-1:0] tbl_addr;
  logic          tbl_we;
  logic [15:0]   tbl_start, tbl_len;
  // pcm memory
  logic [PB-1:0] pcm_addr;
  logic          pcm_we;
  logic [15:0]   pcm_rd;

  pvm_ram #(.WIDTH(16), .DEPTH(MAX_SOUNDS)) u_start (
    .clk, .we(tbl_we), .addr(tbl_addr), .wdata(it_r.address), .rdata(tbl_start));
  pvm_ram #(.WIDTH(16), .DEPTH(MAX_SOUNDS)) u_len (
    .clk, .we(tbl_we), .addr(tbl_addr), .wdata(it_r.length), .rdata(tbl_len));
  pvm_ram #(.WIDTH(16), .DEPTH(PCM_DEPTH)) u_pcm (
    .clk, .we(pcm_we), .addr(pcm_addr), .wdata(it_r.pcm_sample), .rdata(pcm_rd));

  // Tick voice visit: vstart reads the table, then the pcm read is issued in
  // the wait cycle using table data with cursor wrap applied; vfinish uses it.
  logic [15:0] cur_eff;
  logic        wrap0;
  always_comb begin
    wrap0   = (vcur_r[vi_r] >= tbl_len);
    cur_eff = wrap0 ? 16'd0 : vcur_r[vi_r];
  end

  always_comb begin
    tbl_we   = cmd.exec && it_r.operation == pvm_pkg::OP_LENTRY
               && ({5'd0, it_r.snd_sel} < 9'(MAX_SOUNDS));
    tbl_addr = cmd.exec ? SB'(it_r.snd_sel) : SB'(vsnd_r[vi_r]);
    pcm_we   = cmd.exec && it_r.operation == pvm_pkg::OP_LPCM;
    pcm_addr = cmd.exec ? PB'(it_r.address)
                        : PB'({1'b0, tbl_start} + {1'b0, cur_eff});
  end

  // lowest voice matching handle by mode
  logic        fnd;
  logic [VB-1:0] fidx;
  logic        free_any;
  logic [VB-1:0] fslot;
  logic        hit;
  always_comb begin
    fnd = 1'b0; fidx = '0; free_any = 1'b0; fslot = '0; hit = 1'b0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (it_r.handle != 16'd0 && 16'(vhdl_r[v]) == it_r.handle
          && vstate_r[v] != pvm_pkg::VS_FREE
          && !(it_r.operation == pvm_pkg::OP_PAUSE && vstate_r[v] != pvm_pkg::VS_PLAY)
          && !(it_r.operation == pvm_pkg::OP_RESUME && vstate_r[v] != pvm_pkg::VS_PAUSE))
      begin
        fnd = 1'b1; fidx = VB'(v);
      end
      if (vstate_r[v] == pvm_pkg::VS_FREE) begin
        free_any = 1'b1; fslot = VB'(v);
      end
      if (vstate_r[v] != pvm_pkg::VS_FREE && vhdl_r[v] == nh_r) hit = 1'b1;
    end
  end

  logic bad_id;
  assign bad_id = ({5'd0, it_r.snd_sel} >= {4'd0, sound_count})
                  || ({5'd0, it_r.snd_sel} >= 9'(MAX_SOUNDS));

  assign st.operation  = it_r.operation;
  assign st.last_voice = (vi_r == VB'(VOICES - 1));
  assign st.play_ok    = !bad_id && free_any;
  assign st.hdl_done   = got_r || (tries_r == CB'(VOICES + 1));

  // sample read during visit
  logic signed [ACCB-1:0] add_v;
  logic [15:0] cnext;
  always_comb begin
    add_v = '0;
    cnext = len_r == 16'd0 ? 16'd0 : curv_r + 16'd1;
    if (len_r != 16'd0) add_v = ACCB'(signed'(pcm_rd));
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) it_r <= item;
    if (cmd.vstart) begin
      vplay_r <= (vstate_r[vi_r] == pvm_pkg::VS_PLAY);
    end
    // wait cycle: table data valid, record cursor and length
    if (!cmd.vstart && !cmd.vfinish && !cmd.exec) begin
      len_r  <= tbl_len;
      curv_r <= cur_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICES; v++) begin
        vstate_r[v] <= pvm_pkg::VS_FREE;
        vhdl_r[v]   <= '0;
        vsnd_r[v]   <= '0;
        vcur_r[v]   <= '0;
        vloop_r[v]  <= 1'b0;
      end
      nh_r <= HANDLE_BITS'(1);
      vi_r <= '0; tries_r <= '0; got_r <= 1'b0;
      status_r <= pvm_pkg::ST_OK; pos_r <= '0; hout_r <= '0; slot_r <= '0;
      acc_r <= '0; nmix_r <= '0;
    end else begin
      if (cmd.exec) begin
        vi_r <= '0; tries_r <= '0; got_r <= 1'b0;
        status_r <= pvm_pkg::ST_OK; pos_r <= '0; hout_r <= '0;
        acc_r <= '0; nmix_r <= '0; slot_r <= fslot;
        case (it_r.operation)
          pvm_pkg::OP_PLAY: begin
            if (bad_id) status_r <= pvm_pkg::ST_BAD_ID;
            else if (!free_any) status_r <= pvm_pkg::ST_NO_VOICE;
          end
          pvm_pkg::OP_PAUSE, pvm_pkg::OP_RESUME, pvm_pkg::OP_STOP,
          pvm_pkg::OP_QUERY: begin
            if (!fnd) status_r <= pvm_pkg::ST_NOT_FND;
            else begin
              case (it_r.operation)
                pvm_pkg::OP_PAUSE:  vstate_r[fidx] <= pvm_pkg::VS_PAUSE;
                pvm_pkg::OP_RESUME: vstate_r[fidx] <= pvm_pkg::VS_PLAY;
                pvm_pkg::OP_STOP:   vstate_r[fidx] <= pvm_pkg::VS_FREE;
                default:            pos_r <= vcur_r[fidx];
              endcase
            end
          end
          default: ;
        endcase
      end
      if (cmd.try_hdl && !st.hdl_done) begin
        nh_r <= (nh_r >= HMAX) ? HANDLE_BITS'(1) : nh_r + HANDLE_BITS'(1);
        tries_r <= tries_r + CB'(1);
        if (!hit) begin
          got_r <= 1'b1;
          hout_r <= nh_r;
          vstate_r[slot_r] <= pvm_pkg::VS_PLAY;
          vhdl_r[slot_r]   <= nh_r;
          vsnd_r[slot_r]   <= it_r.snd_sel;
          vcur_r[slot_r]   <= '0;
          vloop_r[slot_r]  <= it_r.looping;
        end else if (tries_r == CB'(VOICES)) begin
          status_r <= pvm_pkg::ST_NO_HDL;
        end
      end
      if (cmd.vfinish) begin
        vi_r <= vi_r + VB'(1);
        if (vplay_r) begin
          nmix_r <= nmix_r + 3'd1;
          if (!vloop_r[vi_r] && vcur_r[vi_r] >= len_r) begin
            vstate_r[vi_r] <= pvm_pkg::VS_FREE;
          end else begin
            acc_r <= acc_r + add_v;
            if (len_r != 16'd0 && cnext >= len_r) begin
              vcur_r[vi_r] <= 16'd0;
              if (!vloop_r[vi_r]) vstate_r[vi_r] <= pvm_pkg::VS_FREE;
            end else begin
              vcur_r[vi_r] <= cnext;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.mixed_sample = 16'd0;
    if (it_r.operation == pvm_pkg::OP_TICK) begin
      if (acc_r > ACCB'(32767)) res.mixed_sample = 16'h7fff;
      else if (acc_r < -ACCB'(32768)) res.mixed_sample = 16'h8000;
      else res.mixed_sample = acc_r[15:0];
    end
    res.voices_mixed = nmix_r;
    res.handle_out   = 16'(hout_r);
    res.position     = pos_r;
    res.status       = (it_r.operation == pvm_pkg::OP_PLAY && status_r == pvm_pkg::ST_OK
                        && !got_r) ? pvm_pkg::ST_NO_HDL : status_r;
  end

  a_vi: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> vi_r == '0) else $error("voice index not cleared");
  a_nmix: assert property (@(posedge clk) disable iff (!rst_n)
    nmix_r <= 3'(VOICES) || VOICES > 7) else $error("voice count overflow");
  a_got: assert property (@(posedge clk) disable iff (!rst_n)
    got_r |-> hout_r != '0) else $error("zero handle given");
endmodule
`default_nettype wire

// File: sv/pcm_voice_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_voice_mixer: four-voice PCM playback mixer
// Sound table, pcm store, voice slots with handles; tick mixes all voices.
// ----------------------------------------------------------------------------
// channel  dir  beat payload
// in_      in   operation, snd_sel, looping, handle, address, length, pcm_sample
// out_     out  mixed_sample, voices_mixed, handle_out, position, status
// cfg_     in   sound_count (write enable + data)
//
// One item at a time. Non-tick ops go latch, execute, result; play adds a
// handle search over up to VOICES+1 candidates, and tick visits one voice at
// a time, table read then pcm read through the one pcm memory port.
// Reset: synchronous active low; voices free, next handle 1. Table and pcm
// memory are not cleared. A result waits in its register while out_ stalls;
// the next item is still taken and its result is held back in the sequencer
// until that register has been handed over.
// ----------------------------------------------------------------------------
module pcm_voice_mixer #(
  parameter int VOICES      = pvm_pkg::VOICES_DEF,
  parameter int MAX_SOUNDS  = pvm_pkg::MAX_SOUNDS_DEF,
  parameter int PCM_DEPTH   = pvm_pkg::PCM_DEPTH_DEF,
  parameter int HANDLE_BITS = pvm_pkg::HANDLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pvm_stream_if.sink      in_ch,
  pvm_stream_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);
  logic [4:0] sound_count_r;
  pvm_pkg::cmd_t    cmd;
  pvm_pkg::stat_t   st;
  pvm_pkg::result_t res, res_r;
  logic out_valid_r;
  logic rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) sound_count_r <= '0;
    else if (cfg_we) sound_count_r <= cfg_wdata;
  end

  assign in_ch.ready = rdy;

  pvm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire (in_ch.valid && rdy),
    .res_busy(out_valid_r && !out_ch.ready),
    .st, .in_ready(rdy), .cmd);

  pvm_dp #(.VOICES(VOICES), .MAX_SOUNDS(MAX_SOUNDS), .PCM_DEPTH(PCM_DEPTH),
           .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .item(in_ch.data), .sound_count(sound_count_r),
    .st, .res);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (cmd.finish) res_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  a_no_ovr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_ch.ready)) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("beat dropped");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && rdy |=> !rdy) else $error("took two items");
endmodule
`default_nettype wire

// File: tb/pcm_voice_mixer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_voice_mixer_test: self-checking bench for the four-voice PCM mixer
// A directed table covers the bad-id, no-voice and not-found codes, extremes
// and saturation. Random command traffic follows over several sound_count
// settings. Every result beat is checked field by field against a behavioral copy of the mixer or a typed-in result.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_test;
  import pvm_pkg::*;

  localparam int NVOICE     = 4;
  localparam int NSOUND     = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 20;
  localparam int PHASE_LEN  = 215;
  localparam logic [15:0] WIN_BASE = 16'd65528; // written window wraps past 0
  localparam int WIN_SIZE   = 72;

  typedef struct {
    item_t   it;
    bit      set_count;  // write sound_count = 16 before this row
    bit      fixed;      // want holds a typed-in result
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  pvm_stream_if #(.T(item_t))   in_if ();
  pvm_stream_if #(.T(result_t)) out_if ();

  pcm_voice_mixer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mixer state mirror
  // --------------------------------------------------------------------------
  logic [4:0]  mir_count;
  logic [1:0]  mir_state  [NVOICE];
  logic [15:0] mir_handle [NVOICE];
  logic [3:0]  mir_sound  [NVOICE];
  logic [15:0] mir_cursor [NVOICE];
  logic        mir_loop   [NVOICE];
  logic [15:0] mir_next;
  logic [15:0] mir_start  [NSOUND];
  logic [15:0] mir_len    [NSOUND];
  logic [15:0] mir_pcm    [0:65535];
  bit          pcm_written[0:65535];  // reads of unwritten words must never happen

  result_t pending_results[$];
  int      err_count = 0;
  int      beats_in = 0, beats_out = 0, ticks_sent = 0, plays_ok = 0;
  int      cycles = 0;
  bit      tx_lazy = 1'b0, rx_lazy = 1'b0;
  bit      hold_req = 1'b0;

  // Apply one command to the mirror and return the result it produces.
  function automatic result_t mixer_apply(item_t it);
    result_t r;
    int      acc;
    int      slot;
    int      hit_v;
    bit      got, hit;
    logic [15:0] cand, ln, cur;
    r = '0;
    acc = 0;
    case (it.operation)
      OP_TICK: begin
        for (int v = 0; v < NVOICE; v++) begin
          if (mir_state[v] != VS_PLAY) continue;
          r.voices_mixed++;
          ln  = mir_len[mir_sound[v]];
          cur = mir_cursor[v];
          if (cur >= ln) begin
            if (!mir_loop[v]) begin
              mir_state[v] = VS_FREE;
              continue;
            end
            cur = '0;
          end
          if (cur < ln) begin
            acc += $signed(mir_pcm[16'(mir_start[mir_sound[v]] + cur)]);
            cur++;
            if (cur >= ln) begin
              if (mir_loop[v]) cur = '0;
              else mir_state[v] = VS_FREE;
            end
          end
          mir_cursor[v] = cur;
        end
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        r.mixed_sample = 16'(acc);
      end
      OP_PLAY: begin
        slot = -1;
        got  = 1'b0;
        if (it.snd_sel >= mir_count) begin
          r.status = ST_BAD_ID;
        end else begin
          for (int v = NVOICE - 1; v >= 0; v--)
            if (mir_state[v] == VS_FREE) slot = v;
          if (slot < 0) begin
            r.status = ST_NO_VOICE;
          end else begin
            for (int a = 0; a <= NVOICE && !got; a++) begin
              cand = mir_next;
              mir_next = (mir_next == 16'hFFFF) ? 16'd1 : mir_next + 16'd1;
              hit = 1'b0;
              for (int v = 0; v < NVOICE; v++)
                if (mir_state[v] != VS_FREE && mir_handle[v] == cand) hit = 1'b1;
              got = !hit;
            end
            if (!got) begin
              r.status = ST_NO_HDL;
            end else begin
              mir_state[slot]  = VS_PLAY;
              mir_handle[slot] = cand;
              mir_sound[slot]  = it.snd_sel;
              mir_cursor[slot] = '0;
              mir_loop[slot]   = it.looping;
              r.handle_out     = cand;
            end
          end
        end
      end
      OP_PAUSE, OP_RESUME, OP_STOP, OP_QUERY: begin
        hit_v = -1;
        if (it.handle != 0)
          for (int v = NVOICE - 1; v >= 0; v--) begin
            if (mir_handle[v] != it.handle || mir_state[v] == VS_FREE) continue;
            if (it.operation == OP_PAUSE && mir_state[v] != VS_PLAY) continue;
            if (it.operation == OP_RESUME && mir_state[v] != VS_PAUSE) continue;
            hit_v = v;
          end
        if (hit_v < 0) r.status = ST_NOT_FND;
        else case (it.operation)
          OP_PAUSE:  mir_state[hit_v] = VS_PAUSE;
          OP_RESUME: mir_state[hit_v] = VS_PLAY;
          OP_STOP:   mir_state[hit_v] = VS_FREE;
          default:   r.position = mir_cursor[hit_v];
        endcase
      end
      OP_LENTRY: begin
        mir_start[it.snd_sel] = it.address;
        mir_len[it.snd_sel]   = it.length;
      end
      default: begin
        mir_pcm[it.address]     = it.pcm_sample;
        pcm_written[it.address] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Handle of a playing voice whose next tick would touch an unwritten word,
  // or 0 when a tick is safe.
  function automatic logic [15:0] unsafe_voice();
    logic [15:0] ln, cur;
    for (int v = 0; v < NVOICE; v++) begin
      if (mir_state[v] != VS_PLAY) continue;
      ln  = mir_len[mir_sound[v]];
      cur = mir_cursor[v];
      if (cur >= ln) begin
        if (!mir_loop[v]) continue;
        cur = '0;
      end
      if (cur < ln && !pcm_written[16'(mir_start[mir_sound[v]] + cur)])
        return mir_handle[v];
    end
    return '0;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (rx_lazy) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Scoreboard: compare each accepted result beat with the oldest pending one
  always @(posedge clk) begin
    result_t got, want;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      beats_out++;
      if (pending_results.size() == 0) begin
        report("unexpected beat", 16'(got.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.mixed_sample !== want.mixed_sample)
          report("mixed_sample", got.mixed_sample, want.mixed_sample);
        if (got.voices_mixed !== want.voices_mixed)
          report("voices_mixed", 16'(got.voices_mixed), 16'(want.voices_mixed));
        if (got.handle_out !== want.handle_out)
          report("handle_out", got.handle_out, want.handle_out);
        if (got.position !== want.position)
          report("position", got.position, want.position);
        if (got.status !== want.status)
          report("status", 16'(got.status), 16'(want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Offer one beat (after an optional gap) and record its result on accept.
  task automatic send_cmd(item_t it, bit fixed = 1'b0, result_t want = '0);
    result_t r;
    int gap;
    gap = tx_lazy ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = it;
    do @(posedge clk); while (!in_if.ready);
    r = mixer_apply(it);
    pending_results.push_back(fixed ? want : r);
    beats_in++;
    if (it.operation == OP_TICK) ticks_sent++;
    if (it.operation == OP_PLAY && r.status == ST_OK) plays_ok++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Wait until every expected result has been taken
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Register writes only with nothing in flight
  task automatic write_count(logic [4:0] n);
    drop_valid();
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = n;
    @(negedge clk);
    cfg_we    = 1'b0;
    mir_count = n;
  endtask

  // Table entry whose whole sample range lies inside the written window
  function automatic item_t safe_entry(item_t it);
    int off;
    off = $urandom_range(0, WIN_SIZE - 1);
    it.operation = OP_LENTRY;
    it.address   = WIN_BASE + 16'(off);
    it.length    = 16'($urandom_range(1, WIN_SIZE - off));
    return it;
  endfunction

  function automatic logic [15:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return mir_handle[$urandom_range(0, NVOICE - 1)];
    if (r == 7) return '0;
    return 16'($urandom);
  endfunction

  function automatic item_t random_cmd();
    item_t it;
    int r;
    it = item_t'({$urandom, $urandom, $urandom});
    it.handle = pick_handle();
    if (it.length == 0) it.length = 16'd1;
    r = $urandom_range(0, 99);
    if (r < 35)      it.operation = OP_TICK;
    else if (r < 50) it.operation = OP_PLAY;
    else if (r < 57) it.operation = OP_PAUSE;
    else if (r < 64) it.operation = OP_RESUME;
    else if (r < 71) it.operation = OP_STOP;
    else if (r < 78) it.operation = OP_QUERY;
    else if (r < 86) begin
      // long or far entries now and then; ticks are steered around them
      if ($urandom_range(0, 4) != 0) it = safe_entry(it);
      else it.operation = OP_LENTRY;
    end else begin
      it.operation = OP_LPCM;
      if ($urandom_range(0, 2) != 0)
        it.address = WIN_BASE + 16'($urandom_range(0, WIN_SIZE - 1));
    end
    // a tick that would read past the written data becomes a stop instead
    if (it.operation == OP_TICK && unsafe_voice() != 0) begin
      it.operation = OP_STOP;
      it.handle    = unsafe_voice();
    end
    return it;
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(logic [2:0] op, logic [3:0] sid, logic lp,
                                  logic [15:0] h, logic [15:0] a, logic [15:0] ln,
                                  logic [15:0] smp, bit cnt, bit fx, result_t w);
    row_t row;
    row.it        = '{op, sid, lp, h, a, ln, smp};
    row.set_count = cnt;
    row.fixed     = fx;
    row.want      = w;
    dir_rows.push_back(row);
  endfunction

  initial begin
    item_t it;
    logic [4:0] phase_counts [6] = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd16, 5'd9};

    in_if.valid = 1'b0;
    in_if.data  = '0;
    mir_count   = '0;
    mir_next    = 16'd1;
    for (int v = 0; v < NVOICE; v++) begin
      mir_state[v]  = VS_FREE;
      mir_handle[v] = '0;
      mir_sound[v]  = '0;
      mir_cursor[v] = '0;
      mir_loop[v]   = 1'b0;
    end

    // sound_count 0: nothing plays, unknown handles are rejected
    add_row(OP_TICK,   4'd0, 1'b0, 16'h0000, 16'h0000, 16'd1, 16'h0000, 0, 1, '0);
    add_row(OP_PLAY,   4'd0, 1'b0, 16'h0000, 16'h0000, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_BAD_ID});
    add_row(OP_PAUSE,  4'd0, 1'b0, 16'h0000, 16'h0000, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_NOT_FND});
    add_row(OP_RESUME, 4'd0, 1'b0, 16'hFFFF, 16'h0000, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_NOT_FND});
    add_row(OP_STOP,   4'd0, 1'b0, 16'h0001, 16'h0000, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_NOT_FND});
    add_row(OP_QUERY,  4'd0, 1'b0, 16'h0001, 16'h0000, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_NOT_FND});
    // full-scale samples for saturation
    add_row(OP_LPCM,   4'd0, 1'b0, 16'h0000, 16'd0, 16'd1, 16'h7FFF, 0, 0, '0);
    add_row(OP_LPCM,   4'd0, 1'b0, 16'h0000, 16'd1, 16'd1, 16'h7FFF, 0, 0, '0);
    add_row(OP_LPCM,   4'd0, 1'b0, 16'h0000, 16'd2, 16'd1, 16'h8000, 0, 0, '0);
    add_row(OP_LPCM,   4'd0, 1'b0, 16'h0000, 16'd3, 16'd1, 16'h8000, 0, 0, '0);
    add_row(OP_LENTRY, 4'd0, 1'b0, 16'h0000, 16'd0, 16'd2, 16'h0000, 0, 0, '0);
    add_row(OP_LENTRY, 4'd1, 1'b0, 16'h0000, 16'd2, 16'd2, 16'h0000, 0, 0, '0);
    // top entry wraps the pcm address space
    add_row(OP_LENTRY, 4'd15, 1'b0, 16'h0000, 16'hFFFF, 16'd3, 16'h0000, 0, 0, '0);
    // sound_count 16: fill all four voices, then one too many
    add_row(OP_PLAY,   4'd0, 1'b1, 16'h0000, 16'd0, 16'd1, 16'h0000, 1, 1,
            '{16'h0, 3'd0, 16'h1, 16'h0, ST_OK});
    add_row(OP_PLAY,   4'd0, 1'b1, 16'h0000, 16'd0, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h2, 16'h0, ST_OK});
    add_row(OP_PLAY,   4'd0, 1'b0, 16'h0000, 16'd0, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h3, 16'h0, ST_OK});
    add_row(OP_PLAY,   4'd15, 1'b0, 16'h0000, 16'd0, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h4, 16'h0, ST_OK});
    add_row(OP_PLAY,   4'd1, 1'b0, 16'h0000, 16'd0, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_NO_VOICE});
    add_row(OP_TICK,   4'd0, 1'b0, 16'h0000, 16'd0, 16'd1, 16'h0000, 0, 0, '0);
    add_row(OP_PAUSE,  4'd0, 1'b0, 16'h0001, 16'd0, 16'd1, 16'h0000, 0, 0, '0);
    add_row(OP_RESUME, 4'd0, 1'b0, 16'h0002, 16'd0, 16'd1, 16'h0000, 0, 1,
            '{16'h0, 3'd0, 16'h0, 16'h0, ST_NOT_FND});
    add_row(OP_RESUME, 4'd0, 1'b0, 16'h0001, 16'd0, 16'd1, 16'h0000, 0, 0, '0);
    add_row(OP_QUERY,  4'd0, 1'b0, 16'h0003, 16'd0, 16'd1, 16'h0000, 0, 0, '0);
    add_row(OP_STOP,   4'd0, 1'b0, 16'h0003, 16'd0, 16'd1, 16'h0000, 0, 0, '0);
    add_row(OP_TICK,   4'd0, 1'b0, 16'h0000, 16'd0, 16'd1, 16'h0000, 0, 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Written window and a safe table: the store is undefined until loaded
    for (int k = 0; k < WIN_SIZE; k++) begin
      it = item_t'({$urandom, $urandom, $urandom});
      it.operation = OP_LPCM;
      it.address   = WIN_BASE + 16'(k);
      send_cmd(it);
    end
    for (int s = 0; s < NSOUND; s++) begin
      it = safe_entry(item_t'({$urandom, $urandom, $urandom}));
      it.snd_sel = 4'(s);
      send_cmd(it);
    end

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_count) write_count(5'd16);
      send_cmd(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want);
    end

    // Random traffic over several table sizes and idling mixes
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      tx_lazy = (p % 3) != 1;
      rx_lazy = (p % 3) != 2;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 1 && n == 30) hold_req = 1'b1;  // back up the result side
        if (p == 2 && n == 100) begin             // let everything drain once
          drop_valid();
          wait_drained();
        end
        send_cmd(random_cmd());
      end
    end

    drop_valid();
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d command beats (%0d ticks, %0d voices started), checked %0d results",
             beats_in, ticks_sent, plays_ok, beats_out);
    $display("Table sizes 0, 1, 5, 9 and 16 used; %0d mismatches", err_count);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
